// File: hw/rtl/haptic_pattern_player_assert.svh
// ----------------------------------------------------------------------------
// haptic_pattern_player_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef HAPTIC_PATTERN_PLAYER_ASSERT_SVH
`define HAPTIC_PATTERN_PLAYER_ASSERT_SVH

// assertion that is switched off while reset is high
`define HPP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hpp assertion failed");

// assertion that is also checked during reset
`define HPP_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hpp reset assertion failed");

`endif

// File: hw/rtl/hpp_pkg.sv
// ----------------------------------------------------------------------------
// hpp_pkg
// shared constants, types and the strength-to-duty table of the pattern player
// ----------------------------------------------------------------------------
`default_nettype none

package hpp_pkg;

  localparam int MAX_STEPS_DEF = 12;
  localparam int DUR_W         = 16;
  localparam int FUNC_W        = 2;
  localparam int LEVEL_W       = 2;
  localparam int DUTY_W        = 8;
  localparam int IN_USER_W     = 3;
  localparam int OUT_DATA_W    = 16;
  localparam int CFG_DATA_W    = 2;
  localparam int CFG_IDX_W     = 1;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 1'd1;

  localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH   = 2'd2;

  localparam logic [DUTY_W-1:0] DUTY_LOW    = 8'd90;
  localparam logic [DUTY_W-1:0] DUTY_MEDIUM = 8'd170;
  localparam logic [DUTY_W-1:0] DUTY_HIGH   = 8'd255;

  typedef struct packed {
    logic               enabled;
    logic [LEVEL_W-1:0] strength_level;
    logic               halt;
  } cfg_t;

  typedef struct packed {
    logic motor_on;
    logic playing;
  } stat_t;

  function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] level);
    logic [DUTY_W-1:0] duty;
    unique case (level)
      LEVEL_LOW:    duty = DUTY_LOW;
      LEVEL_MEDIUM: duty = DUTY_MEDIUM;
      default:      duty = DUTY_HIGH;
    endcase
    return duty;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hpp_cfg_regs.sv
// ----------------------------------------------------------------------------
// hpp_cfg_regs
// enable and strength registers, with a stop pulse when playback is disabled
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_cfg_regs (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [hpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [hpp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output hpp_pkg::cfg_t                      cfg
);

  logic                           enabled;
  logic [hpp_pkg::LEVEL_W-1:0]    strength_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b1;
      strength_level <= hpp_pkg::LEVEL_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpp_pkg::REG_ENABLED:  enabled        <= cfg_data[0];
        hpp_pkg::REG_STRENGTH: strength_level <= cfg_data[hpp_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.enabled        = enabled;
    cfg.strength_level = strength_level;
    cfg.halt           = cfg_we && (cfg_index == hpp_pkg::REG_ENABLED) && !cfg_data[0];
  end

endmodule

`default_nettype wire

// File: hw/rtl/hpp_core.sv
// ----------------------------------------------------------------------------
// hpp_core
// step store and playback state, updated once per request and cleared on a halt
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_core #(
  parameter int MAX_STEPS = hpp_pkg::MAX_STEPS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              fire,
  input  wire  [hpp_pkg::FUNC_W-1:0]       func,
  input  wire  [hpp_pkg::DUR_W-1:0]        step_duration,
  input  wire                              first_step,
  input  wire                              last_step,
  input  wire  hpp_pkg::cfg_t              cfg,
  output hpp_pkg::stat_t                   stat_next
);

  localparam int IW = $clog2(MAX_STEPS);
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STEPS);

  logic [hpp_pkg::DUR_W-1:0] step_store [MAX_STEPS];
  logic [hpp_pkg::DUR_W-1:0] first_dur;

  logic [CW-1:0]             pattern_length;
  logic [CW-1:0]             step_index;
  logic [hpp_pkg::DUR_W-1:0] ticks_left;
  logic                      active;
  logic                      drive_state;

  logic [CW-1:0]             pattern_length_next;
  logic [CW-1:0]             step_index_next;
  logic [hpp_pkg::DUR_W-1:0] ticks_left_next;
  logic                      active_next;
  logic                      drive_state_next;

  logic                      store_we;
  logic [IW-1:0]             store_addr;
  logic                      first_we;
  logic [CW-1:0]             base_len;
  logic [CW-1:0]             idx_inc;
  logic [hpp_pkg::DUR_W-1:0] dec;

  always_comb begin
    pattern_length_next = pattern_length;
    step_index_next     = step_index;
    ticks_left_next     = ticks_left;
    active_next         = active;
    drive_state_next    = drive_state;
    store_we            = 1'b0;
    first_we            = 1'b0;
    base_len            = first_step ? '0 : pattern_length;
    store_addr          = base_len[IW-1:0];
    idx_inc             = step_index + CW'(1);
    dec                 = (ticks_left != '0) ? ticks_left - hpp_pkg::DUR_W'(1) : ticks_left;
    unique case (func)
      hpp_pkg::FUNC_TICK: begin
        if (active) begin
          ticks_left_next = dec;
          if (dec == '0) begin
            step_index_next = idx_inc;
            if (idx_inc >= pattern_length) begin
              drive_state_next = 1'b0;
              active_next      = 1'b0;
            end else begin
              drive_state_next = ~idx_inc[0];
              ticks_left_next  = step_store[idx_inc[IW-1:0]];
            end
          end
        end
      end
      hpp_pkg::FUNC_LOAD: begin
        if (first_step) begin
          drive_state_next    = 1'b0;
          active_next         = 1'b0;
          step_index_next     = '0;
          pattern_length_next = '0;
        end
        if (base_len < MAX_CNT) begin
          store_we            = 1'b1;
          first_we            = (base_len == '0);
          pattern_length_next = base_len + CW'(1);
        end
        if (last_step && cfg.enabled && (pattern_length_next != '0)) begin
          step_index_next  = '0;
          active_next      = 1'b1;
          drive_state_next = 1'b1;
          ticks_left_next  = (base_len == '0) ? step_duration : first_dur;
        end
      end
      hpp_pkg::FUNC_STOP: begin
        drive_state_next    = 1'b0;
        active_next         = 1'b0;
        step_index_next     = '0;
        pattern_length_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      step_index     <= '0;
      ticks_left     <= '0;
      active         <= 1'b0;
      drive_state    <= 1'b0;
    end else if (cfg.halt) begin
      pattern_length <= '0;
      step_index     <= '0;
      active         <= 1'b0;
      drive_state    <= 1'b0;
    end else if (fire) begin
      pattern_length <= pattern_length_next;
      step_index     <= step_index_next;
      ticks_left     <= ticks_left_next;
      active         <= active_next;
      drive_state    <= drive_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_we) begin
      step_store[store_addr] <= step_duration;
    end
    if (fire && first_we) begin
      first_dur <= step_duration;
    end
  end

  always_comb begin
    stat_next.motor_on = drive_state_next;
    stat_next.playing  = active_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/haptic_pattern_player.sv
// ----------------------------------------------------------------------------
// haptic_pattern_player
// vibration pattern player: loads step durations, plays them on ticks and
// reports motor state, drive duty and playback status for every request
// ----------------------------------------------------------------------------
//  channel  dir  signals                       contents
//  s_*      in   tvalid tready tdata tuser     tdata step_duration,
//                tlast                         tuser func + first_step,
//                                              tlast last_step
//  m_*      out  tvalid tready tdata           motor_on, drive_duty, playing
//  cfg_*    in   we index data                 enabled, strength_level
//
//  one request per cycle sustained while the result is drained; a request passes
//  the input register, then the state update in hpp_core feeding the result register
//  rst is synchronous: state cleared, enabled set, strength set to high
//  a stalled result holds; the input register still takes a request while the
//  result register is empty or being drained
// ----------------------------------------------------------------------------
`default_nettype none

module haptic_pattern_player #(
  parameter int MAX_STEPS = hpp_pkg::MAX_STEPS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [hpp_pkg::DUR_W-1:0]          s_tdata,   // [15:0] step_duration
  input  wire  [hpp_pkg::IN_USER_W-1:0]      s_tuser,   // [1:0] func, [2] first_step
  input  wire                                s_tlast,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [hpp_pkg::OUT_DATA_W-1:0]     m_tdata,   // [0] motor_on, [8:1] drive_duty,
                                                        // [9] playing, [15:10] zero
  input  wire                                cfg_we,
  input  wire  [hpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [hpp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                          in_valid;
  logic [hpp_pkg::FUNC_W-1:0]    in_func;
  logic [hpp_pkg::DUR_W-1:0]     in_dur;
  logic                          in_first;
  logic                          in_last;

  logic                          out_valid;
  logic                          out_motor;
  logic [hpp_pkg::DUTY_W-1:0]    out_duty;
  logic                          out_play;

  logic                          advance;
  hpp_pkg::cfg_t                 cfg;
  hpp_pkg::stat_t                stat_next;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  hpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hpp_core #(
    .MAX_STEPS (MAX_STEPS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (advance),
    .func          (in_func),
    .step_duration (in_dur),
    .first_step    (in_first),
    .last_step     (in_last),
    .cfg           (cfg),
    .stat_next     (stat_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_func  <= s_tuser[hpp_pkg::FUNC_W-1:0];
      in_first <= s_tuser[hpp_pkg::FUNC_W];
      in_dur   <= s_tdata;
      in_last  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_motor <= stat_next.motor_on;
      out_duty  <= stat_next.motor_on ? hpp_pkg::duty_of(cfg.strength_level) : '0;
      out_play  <= stat_next.playing;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_play, out_duty, out_motor};

endmodule

`default_nettype wire

// File: hw/rtl/hpp_checker.sv
// ----------------------------------------------------------------------------
// hpp_checker
// port-level checks of the pattern player, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "haptic_pattern_player_assert.svh"

module hpp_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                m_tvalid,
  input wire                                m_tready,
  input wire [hpp_pkg::OUT_DATA_W-1:0]      m_tdata
);

  // motor off means zero duty
  `HPP_ASSERT(a_duty_off, clk, rst, m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
  // motor only runs during playback
  `HPP_ASSERT(a_on_playing, clk, rst, m_tvalid && m_tdata[0] |-> m_tdata[9])
  // stalled result holds
  `HPP_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  // reset empties the result register
  `HPP_ASSERT_RST(a_rst_empty, clk, rst |=> !m_tvalid)

endmodule

bind haptic_pattern_player hpp_checker u_hpp_checker (.*);

`default_nettype wire

// File: tb/haptic_pattern_player_tb.sv
// ----------------------------------------------------------------------------
// haptic_pattern_player_tb
// Drives load, tick and stop requests into the pattern player over the input
// stream and checks every result word against an in-bench model of the
// pattern store, step sequencing and strength-to-duty mapping. Runs a short
// directed sequence, then random well-formed patterns mixed with noise under
// several register settings and varying back-pressure on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module haptic_pattern_player_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = hpp_pkg::MAX_STEPS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam logic [hpp_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

  typedef struct {
    logic [hpp_pkg::FUNC_W-1:0] func;
    logic [hpp_pkg::DUR_W-1:0]  dur;
    logic                       first;
    logic                       last;
    bit                         hold;
  } req_t;

  typedef struct {
    logic                       motor;
    logic [hpp_pkg::DUTY_W-1:0] duty;
    logic                       play;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [hpp_pkg::DUR_W-1:0]         s_tdata = '0;   // [15:0] step_duration
  logic [hpp_pkg::IN_USER_W-1:0]     s_tuser = '0;   // [1:0] func, [2] first_step
  logic                              s_tlast = 1'b0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [hpp_pkg::OUT_DATA_W-1:0]    m_tdata;        // [0] motor_on, [8:1] drive_duty,
                                                     // [9] playing, [15:10] zero
  logic                              cfg_we = 1'b0;
  logic [hpp_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [hpp_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

  haptic_pattern_player dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // player model state
  logic [hpp_pkg::DUR_W-1:0]   seq_dur [STEPS];
  int                          seq_len;
  int                          seq_pos;
  logic [hpp_pkg::DUR_W-1:0]   tick_cnt;
  logic                        run_on;
  logic                        motor_q;
  logic                        en_q;
  logic [hpp_pkg::LEVEL_W-1:0] lvl_q;

  req_t    pend_q[$];
  status_t status_q[$];
  int      snd_idle = 0;
  int      rcv_idle = 0;
  int      errs = 0;
  int      cycles = 0;

  task automatic halt_player();
    motor_q = 1'b0;
    run_on  = 1'b0;
    seq_len = 0;
    seq_pos = 0;
  endtask

  task automatic begin_step();
    motor_q  = (seq_pos % 2) == 0;
    tick_cnt = (seq_pos < STEPS) ? seq_dur[seq_pos] : '0;
  endtask

  // advance the model by one request and queue the status it leaves behind
  task automatic apply_request(input logic [hpp_pkg::FUNC_W-1:0] func,
                               input logic [hpp_pkg::DUR_W-1:0] dur,
                               input logic first, input logic last);
    status_t st;
    case (func)
      hpp_pkg::FUNC_TICK: begin
        if (run_on) begin
          if (tick_cnt != 0) tick_cnt = tick_cnt - 1'b1;
          if (tick_cnt == 0) begin
            seq_pos++;
            if (seq_pos >= seq_len) begin
              motor_q = 1'b0;
              run_on  = 1'b0;
            end else begin
              begin_step();
            end
          end
        end
      end
      hpp_pkg::FUNC_LOAD: begin
        if (first) halt_player();
        if (seq_len < STEPS) begin
          seq_dur[seq_len] = dur;
          seq_len++;
        end
        if (last && en_q && seq_len > 0) begin
          seq_pos = 0;
          run_on  = 1'b1;
          begin_step();
        end
      end
      hpp_pkg::FUNC_STOP: halt_player();
      default: ;
    endcase
    st.motor = motor_q;
    st.play  = run_on;
    if (!motor_q) st.duty = '0;
    else if (lvl_q == hpp_pkg::LEVEL_LOW) st.duty = hpp_pkg::DUTY_LOW;
    else if (lvl_q == hpp_pkg::LEVEL_MEDIUM) st.duty = hpp_pkg::DUTY_MEDIUM;
    else st.duty = hpp_pkg::DUTY_HIGH;
    status_q.push_back(st);
  endtask

  // request driver
  always @(posedge clk) begin
    req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) apply_request(s_tuser[1:0], s_tdata, s_tuser[2], s_tlast);
      if (!s_tvalid || s_tready) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= snd_idle &&
            !(pend_q[0].hold && status_q.size() != 0)) begin
          nxt = pend_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.dur;
          s_tuser  <= {nxt.first, nxt.func};
          s_tlast  <= nxt.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(0, 99) >= rcv_idle;
      if (m_tvalid && m_tready) begin
        if (status_q.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("unexpected result %h", m_tdata);
        end else begin
          want = status_q.pop_front();
          if (m_tdata[0] !== want.motor || m_tdata[8:1] !== want.duty ||
              m_tdata[9] !== want.play || m_tdata[15:10] !== '0) begin
            errs++;
            if (errs <= MAX_REPORTS)
              $display("mismatch: exp motor %b duty %0d playing %b, got %h",
                       want.motor, want.duty, want.play, m_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("haptic_pattern_player_tb failed");
      $finish;
    end
  end

  task automatic add_req(input logic [hpp_pkg::FUNC_W-1:0] func,
                         input logic [hpp_pkg::DUR_W-1:0] dur,
                         input logic first, input logic last, input bit hold);
    req_t r;
    r.func  = func;
    r.dur   = dur;
    r.first = first;
    r.last  = last;
    r.hold  = hold;
    pend_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || status_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers, model updated as the write is issued
  task automatic set_regs(input logic en, input logic [hpp_pkg::LEVEL_W-1:0] lvl);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= hpp_pkg::REG_ENABLED;
    cfg_data  <= {1'b0, en};
    en_q = en;
    if (!en) halt_player();
    @(posedge clk);
    cfg_index <= hpp_pkg::REG_STRENGTH;
    cfg_data  <= lvl;
    lvl_q = lvl;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [hpp_pkg::DUR_W-1:0] rand_dur();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return hpp_pkg::DUR_W'($urandom());
    if (r == 1) return '1;
    return hpp_pkg::DUR_W'($urandom_range(0, 5));
  endfunction

  task automatic random_phase(input int n);
    int cnt;
    int len;
    int span;
    int nticks;
    int stop_at;
    logic [hpp_pkg::DUR_W-1:0] d;
    bit broken;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 7) begin
        len    = ($urandom_range(0, 5) == 0) ? $urandom_range(STEPS, STEPS + 2)
                                             : $urandom_range(1, 6);
        broken = $urandom_range(0, 9) == 0;
        span   = 0;
        for (int i = 0; i < len; i++) begin
          d = rand_dur();
          span += (d == 0) ? 1 : int'(d);
          add_req(hpp_pkg::FUNC_LOAD, d, i == 0, (i == len - 1) && !broken,
                  (i == 0) && ($urandom_range(0, 15) == 0));
        end
        nticks  = (span > 40 ? 40 : span) + $urandom_range(0, 3);
        stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nticks) : -1;
        for (int i = 0; i < nticks; i++) begin
          if (i == stop_at)
            add_req(hpp_pkg::FUNC_STOP, hpp_pkg::DUR_W'($urandom()),
                    1'($urandom()), 1'($urandom()), 1'b0);
          else if (i == 1 && $urandom_range(0, 5) == 0)
            add_req(hpp_pkg::FUNC_LOAD, rand_dur(), 1'b0, 1'($urandom()), 1'b0);
          else
            add_req(hpp_pkg::FUNC_TICK, hpp_pkg::DUR_W'($urandom()),
                    1'($urandom()), 1'($urandom()), 1'b0);
        end
        cnt += len + nticks;
      end else begin
        d = hpp_pkg::DUR_W'($urandom());
        add_req(hpp_pkg::FUNC_W'($urandom_range(0, 3)), d,
                1'($urandom()), 1'($urandom()), 1'b0);
        if (pend_q[$].func != FUNC_NONE) cnt++;
      end
    end
  endtask

  initial begin
    en_q     = 1'b1;
    lvl_q    = hpp_pkg::LEVEL_HIGH;
    tick_cnt = '0;
    halt_player();
    for (int i = 0; i < STEPS; i++) seq_dur[i] = '0;
    snd_idle = 17;
    rcv_idle = 76;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // idle requests, then a full pattern with one surplus step carrying the last mark
    add_req(hpp_pkg::FUNC_TICK, '1, 1'b1, 1'b1, 1'b0);
    add_req(FUNC_NONE, 16'h5a5a, 1'b0, 1'b1, 1'b0);
    add_req(hpp_pkg::FUNC_STOP, '0, 1'b0, 1'b0, 1'b0);
    add_req(hpp_pkg::FUNC_LOAD, 16'd1, 1'b1, 1'b0, 1'b0);
    add_req(hpp_pkg::FUNC_LOAD, 16'd0, 1'b0, 1'b0, 1'b0);
    add_req(hpp_pkg::FUNC_LOAD, 16'hffff, 1'b0, 1'b0, 1'b0);
    for (int i = 3; i < STEPS; i++) add_req(hpp_pkg::FUNC_LOAD, 16'd3, 1'b0, 1'b0, 1'b0);
    add_req(hpp_pkg::FUNC_LOAD, 16'h1234, 1'b0, 1'b1, 1'b0);
    repeat (3) add_req(hpp_pkg::FUNC_TICK, '0, 1'b0, 1'b0, 1'b0);
    add_req(hpp_pkg::FUNC_STOP, '1, 1'b1, 1'b1, 1'b1);
    // single zero-length step, then append while playing
    add_req(hpp_pkg::FUNC_LOAD, 16'd0, 1'b1, 1'b1, 1'b0);
    add_req(hpp_pkg::FUNC_TICK, '0, 1'b0, 1'b0, 1'b0);
    add_req(hpp_pkg::FUNC_LOAD, 16'd2, 1'b1, 1'b0, 1'b0);
    add_req(hpp_pkg::FUNC_LOAD, 16'd1, 1'b0, 1'b1, 1'b0);
    add_req(hpp_pkg::FUNC_LOAD, 16'd5, 1'b0, 1'b0, 1'b0);
    repeat (3) add_req(hpp_pkg::FUNC_TICK, '0, 1'b0, 1'b0, 1'b0);
    wait_idle();

    // last step while disabled is stored but does not start
    set_regs(1'b0, hpp_pkg::LEVEL_LOW);
    add_req(hpp_pkg::FUNC_LOAD, 16'd4, 1'b1, 1'b1, 1'b0);
    add_req(hpp_pkg::FUNC_TICK, '0, 1'b0, 1'b0, 1'b0);
    add_req(hpp_pkg::FUNC_LOAD, 16'd3, 1'b0, 1'b1, 1'b0);
    wait_idle();
    set_regs(1'b1, 2'd3);
    add_req(hpp_pkg::FUNC_LOAD, 16'd2, 1'b0, 1'b1, 1'b0);
    repeat (4) add_req(hpp_pkg::FUNC_TICK, '0, 1'b0, 1'b0, 1'b0);
    wait_idle();

    set_regs(1'b1, hpp_pkg::LEVEL_LOW);
    random_phase(200);
    wait_idle();
    set_regs(1'b1, 2'd3);
    random_phase(200);
    wait_idle();

    snd_idle = 76;
    rcv_idle = 17;
    set_regs(1'b0, hpp_pkg::LEVEL_MEDIUM);
    random_phase(60);
    wait_idle();
    set_regs(1'b1, hpp_pkg::LEVEL_MEDIUM);
    random_phase(200);
    wait_idle();

    snd_idle = 0;
    rcv_idle = 0;
    set_regs(1'b1, hpp_pkg::LEVEL_HIGH);
    random_phase(200);
    wait_idle();
    set_regs(1'b1, hpp_pkg::LEVEL_LOW);
    random_phase(190);
    wait_idle();
    repeat (10) @(posedge clk);

    if (errs == 0 && status_q.size() == 0)
      $display("haptic_pattern_player_tb passed");
    else
      $display("haptic_pattern_player_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
